>>> hw/rtl/dhcp_tlv_pkg.sv
// Package: types, constants and helpers shared by the DHCP options TLV parser.
`default_nettype none

package dhcp_tlv_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LimitW   = 9;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned IpW      = 32;
  localparam int unsigned OutDataW = 64;

  localparam logic [ByteW-1:0] OPT_PAD      = 8'h00;
  localparam logic [ByteW-1:0] OPT_END      = 8'hff;
  localparam logic [ByteW-1:0] OPT_HOSTNAME = 8'd12;
  localparam logic [ByteW-1:0] OPT_REQ_IP   = 8'd50;
  localparam logic [ByteW-1:0] OPT_MSG_TYPE = 8'd53;

  localparam logic [ByteW-1:0] LEN_MSG_TYPE = 8'd1;
  localparam logic [ByteW-1:0] LEN_REQ_IP   = 8'd4;

  localparam logic [LimitW-1:0] LIMIT_RESET = 9'd256;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_OVERRUN   = 2'd1;
  localparam logic [StatusW-1:0] ST_HOST_LONG = 2'd2;

  localparam logic [ByteW-1:0] MT_DISCOVER = 8'd1;
  localparam logic [ByteW-1:0] MT_REQUEST  = 8'd3;
  localparam logic [ByteW-1:0] MT_DECLINE  = 8'd4;
  localparam logic [ByteW-1:0] MT_RELEASE  = 8'd7;
  localparam logic [ByteW-1:0] MT_INFORM   = 8'd8;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               host_byte_valid;
    logic [ByteW-1:0]   host_byte;
    logic               final_res;
    logic [StatusW-1:0] status;
    logic               msg_type_valid;
    logic [ByteW-1:0]   msg_type;
    logic               is_client_request;
    logic [IpW-1:0]     req_ip_value;
    logic [ByteW-1:0]   hostname_len;
    logic               has_end;
  } result_t;

  function automatic logic is_client_type(input logic [ByteW-1:0] t);
    return (t == MT_DISCOVER) || (t == MT_REQUEST) || (t == MT_DECLINE) ||
           (t == MT_RELEASE) || (t == MT_INFORM);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dhcp_option_tlv_parser_top.sv
// Top level: DHCP options area TLV parser with stream ports and limit register.
//
// Input stream: one options-area byte per transfer on in_tdata, in_tlast on
// the final byte, in_tuser set for a transfer that marks an empty area.
// Output stream: exactly one result transfer per input transfer. out_tuser
// flags a hostname byte in out_tdata; out_tlast marks the result of the
// final byte, which carries status, message type, requested IP, hostname
// length and end flag (all zero on other results).
// The result is registered and appears in the cycle after its input; one
// byte is taken every cycle unless the receiver stalls. The walker state
// and a single result register set the rate. On a stall the register holds
// its content and in_tready drops until it transfers; no result is lost.
// cfg_data sets hostname_limit; cfg_ready is always high. Write it only
// while no area is in flight.
// Reset clears the walker, empties the result register and sets
// hostname_limit to 256.
`default_nettype none

module dhcp_option_tlv_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // is_last
  input  wire logic        in_tuser,   // is_empty
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] host_byte, [9:8] status, [10] msg_type_valid, [18:11] msg_type,
  // [19] is_client_request, [51:20] req_ip_value, [59:52] hostname_len,
  // [60] has_end, [63:61] zero
  output logic [63:0]      out_tdata,
  output logic             out_tlast,  // final_res
  output logic             out_tuser,  // host_byte_valid
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data    // hostname_limit
);
  import dhcp_tlv_pkg::*;

  logic [LimitW-1:0] limit_r;
  logic              accept;
  logic              can_load;
  result_t           step_result;
  result_t           held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  dhcp_tlv_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (accept),
    .data_byte      (in_tdata),
    .is_last        (in_tlast),
    .is_empty       (in_tuser),
    .hostname_limit (limit_r),
    .result         (step_result)
  );

  dhcp_tlv_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result     (step_result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (held)
  );

  assign out_tuser = held.host_byte_valid;
  assign out_tlast = held.final_res;
  assign out_tdata = {3'b000, held.has_end, held.hostname_len, held.req_ip_value,
                      held.is_client_request, held.msg_type, held.msg_type_valid,
                      held.status, held.host_byte};

endmodule

`default_nettype wire

>>> hw/rtl/dhcp_tlv_walker.sv
// Option walker: parse state, per-byte update and result formation.
`default_nettype none

module dhcp_tlv_walker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [dhcp_tlv_pkg::ByteW-1:0]  data_byte,
  input  wire logic                          is_last,
  input  wire logic                          is_empty,
  input  wire logic [dhcp_tlv_pkg::LimitW-1:0] hostname_limit,
  output dhcp_tlv_pkg::result_t              result
);
  import dhcp_tlv_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [ByteW-1:0]   cur_opt_r, cur_opt_nxt;
  logic [ByteW-1:0]   bytes_left_r, bytes_left_nxt;
  logic [ByteW-1:0]   opt_len_r, opt_len_nxt;
  logic               host_reject_r, host_reject_nxt;
  logic               type_seen_r, type_seen_nxt;
  logic [ByteW-1:0]   type_value_r, type_value_nxt;
  logic [IpW-1:0]     ip_value_r, ip_value_nxt;
  logic [IpW-1:0]     ip_build_r, ip_build_nxt;
  logic [ByteW-1:0]   host_len_r, host_len_nxt;
  logic [StatusW-1:0] err_r, err_nxt;
  logic               end_seen_r, end_seen_nxt;
  logic               complete;
  logic               finish;

  always_comb begin
    phase_nxt       = phase_r;
    cur_opt_nxt     = cur_opt_r;
    bytes_left_nxt  = bytes_left_r;
    opt_len_nxt     = opt_len_r;
    host_reject_nxt = host_reject_r;
    type_seen_nxt   = type_seen_r;
    type_value_nxt  = type_value_r;
    ip_value_nxt    = ip_value_r;
    ip_build_nxt    = ip_build_r;
    host_len_nxt    = host_len_r;
    err_nxt         = err_r;
    end_seen_nxt    = end_seen_r;
    complete        = 1'b0;
    finish          = is_empty || is_last;

    result = '0;

    if (!is_empty) begin
      case (phase_r)
        PH_TYPE: begin
          if (data_byte == OPT_END) begin
            end_seen_nxt = 1'b1;
            phase_nxt    = PH_DONE;
          end else if (data_byte != OPT_PAD) begin
            cur_opt_nxt = data_byte;
            phase_nxt   = PH_LEN;
          end
        end
        PH_LEN: begin
          opt_len_nxt     = data_byte;
          bytes_left_nxt  = data_byte;
          ip_build_nxt    = '0;
          host_reject_nxt = (cur_opt_r == OPT_HOSTNAME) &&
                            !({1'b0, data_byte} < hostname_limit);
          if (data_byte == '0) begin
            complete = 1'b1;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          ip_build_nxt = {ip_build_r[IpW-ByteW-1:0], data_byte};
          if ((cur_opt_r == OPT_HOSTNAME) && !host_reject_r) begin
            result.host_byte_valid = 1'b1;
            result.host_byte       = data_byte;
          end
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_nxt == '0) begin
            complete = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (complete) begin
      phase_nxt = PH_TYPE;
      if ((cur_opt_r == OPT_MSG_TYPE) && (opt_len_nxt == LEN_MSG_TYPE)) begin
        type_seen_nxt  = 1'b1;
        type_value_nxt = ip_build_nxt[ByteW-1:0];
      end
      if (cur_opt_r == OPT_HOSTNAME) begin
        if (host_reject_nxt) begin
          err_nxt   = ST_HOST_LONG;
          phase_nxt = PH_DONE;
        end else begin
          host_len_nxt = opt_len_nxt;
        end
      end
      if ((cur_opt_r == OPT_REQ_IP) && (opt_len_nxt == LEN_REQ_IP)) begin
        ip_value_nxt = ip_build_nxt;
      end
    end

    if (finish) begin
      if ((phase_nxt == PH_VALUE) && (err_nxt == ST_OK)) begin
        err_nxt = ST_OVERRUN;
      end
      result.final_res         = 1'b1;
      result.status            = err_nxt;
      result.msg_type_valid    = type_seen_nxt;
      result.msg_type          = type_seen_nxt ? type_value_nxt : '0;
      result.is_client_request = type_seen_nxt && is_client_type(type_value_nxt);
      result.req_ip_value      = ip_value_nxt;
      result.hostname_len      = host_len_nxt;
      result.has_end           = end_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && finish)) begin
      phase_r       <= PH_TYPE;
      cur_opt_r     <= '0;
      bytes_left_r  <= '0;
      opt_len_r     <= '0;
      host_reject_r <= 1'b0;
      type_seen_r   <= 1'b0;
      type_value_r  <= '0;
      ip_value_r    <= '0;
      ip_build_r    <= '0;
      host_len_r    <= '0;
      err_r         <= ST_OK;
      end_seen_r    <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      cur_opt_r     <= cur_opt_nxt;
      bytes_left_r  <= bytes_left_nxt;
      opt_len_r     <= opt_len_nxt;
      host_reject_r <= host_reject_nxt;
      type_seen_r   <= type_seen_nxt;
      type_value_r  <= type_value_nxt;
      ip_value_r    <= ip_value_nxt;
      ip_build_r    <= ip_build_nxt;
      host_len_r    <= host_len_nxt;
      err_r         <= err_nxt;
      end_seen_r    <= end_seen_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dhcp_tlv_out_reg.sv
// Result register: holds one result until the downstream transfer completes.
`default_nettype none

module dhcp_tlv_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire dhcp_tlv_pkg::result_t result,
  output logic                       can_load,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dhcp_tlv_pkg::result_t      out_result
);
  import dhcp_tlv_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule

`default_nettype wire
